// ----- rtl/srs_pkg.sv -----
// Shared types and constants for the stroke point resampler.
`timescale 1ns / 1ps
package srs_pkg;

    localparam int COORD_BITS = 20;
    localparam int DX_W       = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DX_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int CFG_W      = 16;
    localparam int DIVC_W     = $clog2(DX_W + 1);

    // Configuration register indexes
    localparam logic CFG_MIN_SPACING = 1'b0;
    localparam logic CFG_MAX_SPACING = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         new_stroke;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         last_of_run;
    } t_out_item;

    // One segment queued for resampling: start point, delta and squared length
    typedef struct packed {
        logic signed [COORD_BITS-1:0] prev_x;
        logic signed [COORD_BITS-1:0] prev_y;
        logic signed [DX_W-1:0]       dx;
        logic signed [DX_W-1:0]       dy;
        logic        [D2_W-1:0]       d2;
    } t_seg;

    function automatic logic [DX_W-1:0] mag(input logic signed [DX_W-1:0] v);
        mag = v[DX_W-1] ? DX_W'(-v) : DX_W'(v);
    endfunction

endpackage

// ----- rtl/srs_front.sv -----
// Front end: accepts points, keeps the stored point, drops close points.
`timescale 1ns / 1ps
module srs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  srs_pkg::t_in_item           i_item,
    input  logic [srs_pkg::CFG_W-1:0]   i_min_spacing,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output srs_pkg::t_seg               o_q_data
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQX  = 2'd1;
    localparam logic [1:0] F_SQY  = 2'd2;
    localparam logic [1:0] F_DEC  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_has_prev, n_has_prev;
    logic signed [srs_pkg::COORD_BITS-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [srs_pkg::COORD_BITS-1:0] r_pt_x, n_pt_x, r_pt_y, n_pt_y;
    logic       r_first, n_first;
    logic signed [srs_pkg::DX_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [srs_pkg::SQ_W-1:0] r_a, n_a, r_b, n_b;
    logic [2*srs_pkg::CFG_W-1:0] r_min2, n_min2;
    logic [srs_pkg::D2_W-1:0] d2;
    logic drop;
    logic [srs_pkg::DX_W-1:0] mx, my;

    assign o_stall = (r_state != F_IDLE);
    assign mx = srs_pkg::mag(r_dx);
    assign my = srs_pkg::mag(r_dy);
    assign d2 = srs_pkg::D2_W'(r_a) + srs_pkg::D2_W'(r_b);
    assign drop = !r_first && (d2 < srs_pkg::D2_W'(r_min2));

    // Queue entry: a first point travels as a zero-length segment
    always_comb begin
        o_q_data.prev_x = r_first ? r_pt_x : r_prev_x;
        o_q_data.prev_y = r_first ? r_pt_y : r_prev_y;
        o_q_data.dx     = r_first ? '0 : r_dx;
        o_q_data.dy     = r_first ? '0 : r_dy;
        o_q_data.d2     = r_first ? '0 : d2;
    end
    assign o_q_push = (r_state == F_DEC) && !drop && !i_q_full;

    // Classification sequence
    always_comb begin
        n_state = r_state; n_has_prev = r_has_prev;
        n_prev_x = r_prev_x; n_prev_y = r_prev_y;
        n_pt_x = r_pt_x; n_pt_y = r_pt_y; n_first = r_first;
        n_dx = r_dx; n_dy = r_dy; n_a = r_a; n_b = r_b; n_min2 = r_min2;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_pt_x  = i_item.point_x;
                    n_pt_y  = i_item.point_y;
                    n_first = i_item.new_stroke || !r_has_prev;
                    n_dx = srs_pkg::DX_W'(i_item.point_x) - srs_pkg::DX_W'(r_prev_x);
                    n_dy = srs_pkg::DX_W'(i_item.point_y) - srs_pkg::DX_W'(r_prev_y);
                    n_state = F_SQX;
                end
            end
            F_SQX: begin
                n_a = mx * mx;
                n_min2 = i_min_spacing * i_min_spacing;
                n_state = F_SQY;
            end
            F_SQY: begin
                n_b = my * my;
                n_state = F_DEC;
            end
            F_DEC: begin
                if (drop) begin
                    n_state = F_IDLE;
                end else if (!i_q_full) begin
                    n_prev_x = r_pt_x;
                    n_prev_y = r_pt_y;
                    n_has_prev = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_has_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_has_prev <= n_has_prev;
        end
        r_prev_x <= n_prev_x; r_prev_y <= n_prev_y;
        r_pt_x <= n_pt_x; r_pt_y <= n_pt_y; r_first <= n_first;
        r_dx <= n_dx; r_dy <= n_dy; r_a <= n_a; r_b <= n_b; r_min2 <= n_min2;
    end
endmodule

// ----- rtl/srs_fifo.sv -----
// Two-entry segment queue between front and back end.
`timescale 1ns / 1ps
module srs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srs_pkg::t_seg  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output srs_pkg::t_seg  o_data,
    output logic           o_empty
);
    srs_pkg::t_seg r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= !r_wp;
            if (i_pop && !o_empty) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule

// ----- rtl/srs_back.sv -----
// Back end: finds the segment count, divides once per axis, steps the points out.
`timescale 1ns / 1ps
module srs_back #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [srs_pkg::CFG_W-1:0]  i_max_spacing,
    input  logic                       i_q_empty,
    input  srs_pkg::t_seg              i_q_data,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output srs_pkg::t_out_item         o_item
);
    localparam int NW    = $clog2(MAX_SEGMENTS + 1);
    localparam int RW    = srs_pkg::CFG_W + NW;
    localparam int CMP_W = (2 * RW > srs_pkg::D2_W) ? 2 * RW : srs_pkg::D2_W;
    localparam int DX_W  = srs_pkg::DX_W;
    localparam int CB    = srs_pkg::COORD_BITS;
    localparam int DC_W  = srs_pkg::DIVC_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_SQ   = 3'd1;
    localparam logic [2:0] B_CMP  = 3'd2;
    localparam logic [2:0] B_DIVX = 3'd3;
    localparam logic [2:0] B_DIVY = 3'd4;
    localparam logic [2:0] B_STEP = 3'd5;
    localparam logic [2:0] B_EMIT = 3'd6;

    logic [2:0] r_state, n_state;
    srs_pkg::t_seg r_seg, n_seg;
    logic [NW-1:0] r_k, n_k, r_n, n_n, r_i, n_i;
    logic [RW-1:0] r_reach, n_reach;
    logic [2*RW-1:0] r_sq, n_sq;
    logic [DX_W-1:0] r_quo, n_quo;
    logic [NW-1:0] r_rem, n_rem;
    logic [DC_W-1:0] r_cnt, n_cnt;
    logic signed [DX_W-1:0] r_qdx, n_qdx, r_qdy, n_qdy, r_qx, n_qx, r_qy, n_qy;
    logic [NW-1:0] r_rdx, n_rdx, r_rdy, n_rdy;
    logic [NW:0] r_rx, n_rx, r_ry, n_ry;
    logic r_ov, n_ov;
    srs_pkg::t_out_item r_out, n_out;

    logic hit, out_free, neg, rem_ge;
    logic [NW:0] rem_sh;
    logic signed [DX_W-1:0] fix_q;
    logic [NW-1:0] fix_r;
    logic [NW+1:0] sum_x, sum_y, two_n;

    assign o_valid  = r_ov;
    assign o_item   = r_out;
    assign out_free = !r_ov || !i_stall;
    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;

    assign hit = (CMP_W'(r_sq) >= CMP_W'(r_seg.d2)) || (r_k == NW'(MAX_SEGMENTS));

    // Restoring divider step and sign correction (floor division by n)
    assign rem_sh = {r_rem, r_quo[DX_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_n};
    assign neg    = (r_state == B_DIVX) ? r_seg.dx[DX_W-1] : r_seg.dy[DX_W-1];
    always_comb begin
        if (neg && r_rem != '0) begin
            fix_q = ~r_quo;
            fix_r = r_n - r_rem;
        end else if (neg) begin
            fix_q = -r_quo;
            fix_r = '0;
        end else begin
            fix_q = r_quo;
            fix_r = r_rem;
        end
    end

    // Incremental rounding: remainder kept in [0, 2n)
    assign two_n = (NW+2)'({r_n, 1'b0});
    assign sum_x = (NW+2)'(r_rx) + (NW+2)'({r_rdx, 1'b0});
    assign sum_y = (NW+2)'(r_ry) + (NW+2)'({r_rdy, 1'b0});

    always_comb begin
        n_state = r_state; n_seg = r_seg; n_k = r_k; n_n = r_n; n_i = r_i;
        n_reach = r_reach; n_sq = r_sq; n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt;
        n_qdx = r_qdx; n_qdy = r_qdy; n_qx = r_qx; n_qy = r_qy;
        n_rdx = r_rdx; n_rdy = r_rdy; n_rx = r_rx; n_ry = r_ry;
        n_out = r_out;
        n_ov = r_ov && i_stall;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_seg = i_q_data;
                    n_k = NW'(1);
                    n_reach = RW'(i_max_spacing);
                    n_state = B_SQ;
                end
            end
            B_SQ: begin
                n_sq = r_reach * r_reach;
                n_state = B_CMP;
            end
            B_CMP: begin
                if (hit) begin
                    n_n = r_k;
                    n_i = NW'(1);
                    n_quo = srs_pkg::mag(r_seg.dx);
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = B_DIVX;
                end else begin
                    n_k = r_k + NW'(1);
                    n_reach = r_reach + RW'(i_max_spacing);
                    n_state = B_SQ;
                end
            end
            B_DIVX, B_DIVY: begin
                if (r_cnt != DC_W'(DX_W)) begin
                    n_rem = rem_ge ? NW'(rem_sh - {1'b0, r_n}) : NW'(rem_sh);
                    n_quo = {r_quo[DX_W-2:0], rem_ge};
                    n_cnt = r_cnt + DC_W'(1);
                end else if (r_state == B_DIVX) begin
                    n_qdx = fix_q; n_rdx = fix_r;
                    n_quo = srs_pkg::mag(r_seg.dy);
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = B_DIVY;
                end else begin
                    n_qdy = fix_q; n_rdy = fix_r;
                    n_qx = '0; n_qy = '0;
                    n_rx = (NW+1)'(r_n); n_ry = (NW+1)'(r_n);
                    n_state = B_STEP;
                end
            end
            B_STEP: begin
                if (sum_x >= two_n) begin
                    n_rx = (NW+1)'(sum_x - two_n); n_qx = r_qx + r_qdx + DX_W'(1);
                end else begin
                    n_rx = (NW+1)'(sum_x); n_qx = r_qx + r_qdx;
                end
                if (sum_y >= two_n) begin
                    n_ry = (NW+1)'(sum_y - two_n); n_qy = r_qy + r_qdy + DX_W'(1);
                end else begin
                    n_ry = (NW+1)'(sum_y); n_qy = r_qy + r_qdy;
                end
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_free) begin
                    n_out.out_x = r_seg.prev_x + r_qx[CB-1:0];
                    n_out.out_y = r_seg.prev_y + r_qy[CB-1:0];
                    n_out.last_of_run = (r_i == r_n);
                    n_ov = 1'b1;
                    if (r_i == r_n) begin
                        n_state = B_IDLE;
                    end else begin
                        n_i = r_i + NW'(1);
                        n_state = B_STEP;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
        r_seg <= n_seg; r_k <= n_k; r_n <= n_n; r_i <= n_i;
        r_reach <= n_reach; r_sq <= n_sq; r_quo <= n_quo; r_rem <= n_rem; r_cnt <= n_cnt;
        r_qdx <= n_qdx; r_qdy <= n_qdy; r_qx <= n_qx; r_qy <= n_qy;
        r_rdx <= n_rdx; r_rdy <= n_rdy; r_rx <= n_rx; r_ry <= n_ry;
        r_out <= n_out;
    end
endmodule

// ----- rtl/stroke_point_resampler_top.sv -----
// Top level of the stroke point resampler: configuration, front, queue, back.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out (t_out_item)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Front end: one point at a time; squares dx and min spacing, then dy, then decides.
// Back end per segment: it takes the segment, searches the count n (B_SQ, B_CMP),
// runs the serial divider once per axis (B_DIVX, B_DIVY), then steps through B_STEP
// and B_EMIT for each emitted point; B_EMIT waits while the output is stalled.
// Synchronous active-low reset forgets the stored point and empties the queue.
// A stalled output holds the back end; the queue lets the front end keep taking points until it fills.
`timescale 1ns / 1ps
module stroke_point_resampler_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  srs_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output srs_pkg::t_out_item         o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [srs_pkg::CFG_W-1:0]  i_cfg_data
);
    logic [srs_pkg::CFG_W-1:0] r_min_spacing, r_max_spacing;
    logic q_push, q_full;
    srs_pkg::t_seg  q_in, q_out;
    logic q_pop, q_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_spacing <= srs_pkg::CFG_W'(32);
            r_max_spacing <= srs_pkg::CFG_W'(320);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srs_pkg::CFG_MIN_SPACING: r_min_spacing <= i_cfg_data;
                srs_pkg::CFG_MAX_SPACING: r_max_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_item        (i_in),
        .i_min_spacing (r_min_spacing),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    srs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    srs_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_spacing (r_max_spacing),
        .i_q_empty     (q_empty),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_item        (o_out)
    );

    // Checks
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("queue push while full");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue pop while empty");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");
endmodule
